[design/legv8_subset_execute_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the LEGv8 subset execute unit
// Implication checks on the rising edge of clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LEGV8_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define LEGV8_SUBSET_EXECUTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LSE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("legv8_subset_execute_unit: same-cycle check failed");

// Next-cycle implication.
`define LSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("legv8_subset_execute_unit: next-cycle check failed");

`else

`define LSE_ASSERT_IMPL(label, ante, cons)
`define LSE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/lse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_pkg
// Widths, types, instruction and status codes of the LEGv8 subset execute unit.
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int XLEN        = 32;
	localparam int PC_W        = 16;
	localparam int IMM_W       = 16;
	localparam int CMD_W       = 4;
	localparam int REG_FIELD_W = 5;
	localparam int ST_W        = 2;

	localparam int REG_FIELD_COUNT  = 2 ** REG_FIELD_W;
	localparam int REGISTER_COUNT_DEF = 32;
	localparam int MEMORY_WORDS_DEF   = 4096;

	typedef logic [CMD_W-1:0]       cmd_t;
	typedef logic [ST_W-1:0]        status_t;
	typedef logic [XLEN-1:0]        word_t;
	typedef logic [PC_W-1:0]        pc_t;
	typedef logic [REG_FIELD_W-1:0] reg_field_t;
	typedef logic signed [IMM_W-1:0] imm_t;

	localparam pc_t PC_STEP = pc_t'(4);

	localparam cmd_t CMD_ADD  = 4'd0;
	localparam cmd_t CMD_ADDI = 4'd1;
	localparam cmd_t CMD_SUB  = 4'd2;
	localparam cmd_t CMD_SUBI = 4'd3;
	localparam cmd_t CMD_LDUR = 4'd4;
	localparam cmd_t CMD_STUR = 4'd5;
	localparam cmd_t CMD_CBZ  = 4'd6;
	localparam cmd_t CMD_CBNZ = 4'd7;
	localparam cmd_t CMD_B    = 4'd8;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;

endpackage

[design/lse_instr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_instr_if
// Instruction channel: one decoded instruction per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lse_instr_if;
	import lse_pkg::*;

	logic       valid;
	logic       ready;
	cmd_t       command;
	reg_field_t dest_reg;
	reg_field_t src_a;
	reg_field_t src_b;
	imm_t       immediate;
	pc_t        target;

	modport source (
		output valid, command, dest_reg, src_a, src_b, immediate, target,
		input  ready
	);

	modport sink (
		input  valid, command, dest_reg, src_a, src_b, immediate, target,
		output ready
	);

endinterface

[design/lse_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_result_if
// Result channel: one retirement report per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lse_result_if;
	import lse_pkg::*;

	logic                   valid;
	logic                   ready;
	pc_t                    pc;
	logic                   wrote;
	reg_field_t             dest_index;
	logic signed [XLEN-1:0] dest_value;
	logic                   taken;
	status_t                status;

	modport source (
		output valid, pc, wrote, dest_index, dest_value, taken, status,
		input  ready
	);

	modport sink (
		input  valid, pc, wrote, dest_index, dest_value, taken, status,
		output ready
	);

endinterface

[design/lse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/legv8_subset_execute_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legv8_subset_execute_unit
// Three-stage execute unit for a small LEGv8 integer subset.
// ----------------------------------------------------------------------------
// Usage:
// Decoded instructions arrive as words on the instr channel and one report per
// instruction leaves on the result channel, both with a valid/ready handshake.
// A result word is valid once its instruction has passed the stage 1 and
// stage 2 registers; the unit accepts one instruction every cycle while the
// receiver takes results and no memory sweep runs. The rate is set by the
// register file and data memory, each with one write and registered reads;
// results are forwarded so dependent instructions may follow in the next cycle.
// After arst_n is released the unit sweeps the data memory to zero, one word a
// cycle, through all MEMORY_WORDS words, and holds instr.ready low meanwhile.
// When the receiver stalls, the result word holds, the middle stage keeps
// taking instructions until it is full, and then instr.ready drops.
// ----------------------------------------------------------------------------
`include "legv8_subset_execute_unit_assert.svh"

module legv8_subset_execute_unit #(
	parameter int REGISTER_COUNT = lse_pkg::REGISTER_COUNT_DEF,
	parameter int MEMORY_WORDS   = lse_pkg::MEMORY_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lse_instr_if.sink    instr,
	lse_result_if.source result
);
	import lse_pkg::*;

	localparam int RW = $clog2(REGISTER_COUNT);
	localparam int AW = $clog2(MEMORY_WORDS);
	localparam logic [XLEN:0] MEM_LIMIT = (XLEN + 1)'(MEMORY_WORDS);
	localparam logic [AW-1:0] MEM_LAST  = AW'(MEMORY_WORDS - 1);

	typedef logic [RW-1:0] ridx_t;

	// Register fields are reduced modulo the register count by a constant table.
	ridx_t reg_mod [REG_FIELD_COUNT];

	for (genvar g = 0; g < REG_FIELD_COUNT; g++) begin : g_reg_mod
		localparam int MOD_VAL = g % REGISTER_COUNT;
		assign reg_mod[g] = ridx_t'(MOD_VAL);
	end

	// Handshake and stage enables. Stage 2 is the output register.
	logic en1, en2, accept;
	logic s1_v, s2_v;
	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	assign en2         = !s2_v || result.ready;
	assign en1         = !s1_v || en2;
	assign instr.ready = en1 && !clr_busy_q;
	assign accept      = instr.valid && instr.ready;

	// Stage 0: decode register indexes and launch the register file reads.
	// Port B reads the second source for ADD and SUB and the data or test
	// register for everything else.
	ridx_t ra0, pb0;
	logic  use_b0;

	always_comb begin
		use_b0 = (instr.command == CMD_ADD) || (instr.command == CMD_SUB);
		ra0    = reg_mod[instr.src_a];
		pb0    = use_b0 ? reg_mod[instr.src_b] : reg_mod[instr.dest_reg];
	end

	// Register file write port, driven by the result leaving stage 2.
	logic  s2_wrote, s2_load, s2_taken;
	ridx_t s2_rd;
	word_t s2_val, mem_rdata, wb_val;
	pc_t   s2_pc;
	status_t s2_status;
	logic  wb_fire;

	assign wb_fire = s2_v && s2_wrote && result.ready;
	assign wb_val  = s2_load ? mem_rdata : s2_val;

	word_t rf_a_rdata, rf_b_rdata;

	lse_ram #(
		.WIDTH(XLEN),
		.DEPTH(REGISTER_COUNT)
	) u_rf_a (
		.clk  (clk),
		.we   (wb_fire),
		.waddr(s2_rd),
		.wdata(wb_val),
		.re   (en1),
		.raddr(ra0),
		.rdata(rf_a_rdata)
	);

	lse_ram #(
		.WIDTH(XLEN),
		.DEPTH(REGISTER_COUNT)
	) u_rf_b (
		.clk  (clk),
		.we   (wb_fire),
		.waddr(s2_rd),
		.wdata(wb_val),
		.re   (en1),
		.raddr(pb0),
		.rdata(rf_b_rdata)
	);

	// Stage 1 registers.
	cmd_t  cmd_s1;
	ridx_t rd_s1, ra_s1, pb_s1;
	imm_t  imm_s1;
	pc_t   tgt_s1;

	// The write that landed on the same edge as the stage 1 read: the RAM
	// returned the old contents then, so that value is kept beside it.
	logic  lw_v_q;
	ridx_t lw_idx_q;
	word_t lw_val_q;

	// An entry never written reads as zero.
	logic [REGISTER_COUNT-1:0] rf_vld_q;

	pc_t pc_q;

	function automatic word_t pick_operand(
		input logic  hit_s2,
		input word_t val_s2,
		input logic  hit_lw,
		input word_t val_lw,
		input logic  vld,
		input word_t ram
	);
		word_t r;
		priority if (hit_s2) begin
			r = val_s2;
		end else if (hit_lw) begin
			r = val_lw;
		end else if (vld) begin
			r = ram;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	// Stage 1: operand forwarding, execution, address check, PC update.
	word_t         opa, opb, ext_imm, ex_val;
	logic [XLEN:0] addr_sum;
	logic          addr_ok, ex_wrote, ex_load, ex_store, ex_taken;
	status_t       ex_status;
	pc_t           pc_nx;
	logic [AW-1:0] mem_addr;
	logic          s2_fwd;

	assign s2_fwd = s2_v && s2_wrote;

	always_comb begin
		opa = pick_operand(s2_fwd && (s2_rd == ra_s1), wb_val,
			lw_v_q && (lw_idx_q == ra_s1), lw_val_q, rf_vld_q[ra_s1], rf_a_rdata);
		opb = pick_operand(s2_fwd && (s2_rd == pb_s1), wb_val,
			lw_v_q && (lw_idx_q == pb_s1), lw_val_q, rf_vld_q[pb_s1], rf_b_rdata);

		ext_imm  = {{(XLEN - IMM_W){imm_s1[IMM_W-1]}}, imm_s1};
		// The base register is signed, so the word address may be negative.
		addr_sum = {opa[XLEN-1], opa} + {ext_imm[XLEN-1], ext_imm};
		addr_ok  = !addr_sum[XLEN] && (addr_sum < MEM_LIMIT);
		mem_addr = addr_sum[AW-1:0];

		ex_val    = '0;
		ex_wrote  = 1'b0;
		ex_load   = 1'b0;
		ex_store  = 1'b0;
		ex_taken  = 1'b0;
		ex_status = ST_OK;

		unique case (cmd_s1)
			CMD_ADD: begin
				ex_val   = opa + opb;
				ex_wrote = 1'b1;
			end
			CMD_ADDI: begin
				ex_val   = opa + ext_imm;
				ex_wrote = 1'b1;
			end
			CMD_SUB: begin
				ex_val   = opa - opb;
				ex_wrote = 1'b1;
			end
			CMD_SUBI: begin
				ex_val   = opa - ext_imm;
				ex_wrote = 1'b1;
			end
			CMD_LDUR: begin
				if (addr_ok) begin
					ex_wrote = 1'b1;
					ex_load  = 1'b1;
				end else begin
					ex_status = ST_RANGE;
				end
			end
			CMD_STUR: begin
				if (addr_ok) begin
					ex_store = 1'b1;
				end else begin
					ex_status = ST_RANGE;
				end
			end
			CMD_CBZ: begin
				ex_taken = (opb == '0);
			end
			CMD_CBNZ: begin
				ex_taken = (opb != '0);
			end
			CMD_B: begin
				ex_taken = 1'b1;
			end
			default: begin
				ex_status = ST_INVALID;
			end
		endcase

		priority if (ex_status != ST_OK) begin
			pc_nx = pc_q;
		end else if (ex_taken) begin
			pc_nx = tgt_s1;
		end else begin
			pc_nx = pc_q + PC_STEP;
		end
	end

	// Data memory. Stores write and loads read as they leave stage 1, so a
	// load that follows a store to the same word already sees the new data.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	word_t         mem_wdata;

	always_comb begin
		mem_we    = clr_busy_q || (s1_v && ex_store && en2);
		mem_waddr = clr_busy_q ? clr_addr_q : mem_addr;
		mem_wdata = clr_busy_q ? '0 : opb;
	end

	lse_ram #(
		.WIDTH(XLEN),
		.DEPTH(MEMORY_WORDS)
	) u_dmem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (en2),
		.raddr(mem_addr),
		.rdata(mem_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v       <= 1'b0;
			s2_v       <= 1'b0;
			lw_v_q     <= 1'b0;
			rf_vld_q   <= '0;
			pc_q       <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == MEM_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (en1) begin
				s1_v   <= accept;
				lw_v_q <= wb_fire;
			end
			if (en2) begin
				s2_v <= s1_v;
				if (s1_v) begin
					pc_q <= pc_nx;
				end
			end
			if (wb_fire) begin
				rf_vld_q[s2_rd] <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= instr.command;
			rd_s1  <= reg_mod[instr.dest_reg];
			ra_s1  <= ra0;
			pb_s1  <= pb0;
			imm_s1 <= instr.immediate;
			tgt_s1 <= instr.target;
		end
		if (en1) begin
			lw_idx_q <= s2_rd;
			lw_val_q <= wb_val;
		end
		if (en2) begin
			s2_pc     <= pc_nx;
			s2_wrote  <= ex_wrote;
			s2_load   <= ex_load;
			s2_rd     <= ex_wrote ? rd_s1 : '0;
			s2_val    <= (ex_wrote && !ex_load) ? ex_val : '0;
			s2_taken  <= ex_taken;
			s2_status <= ex_status;
		end
	end

	// Result word.
	assign result.valid      = s2_v;
	assign result.pc         = s2_pc;
	assign result.wrote      = s2_wrote;
	assign result.dest_index = reg_field_t'(s2_rd);
	assign result.dest_value = wb_val;
	assign result.taken      = s2_taken;
	assign result.status     = s2_status;

	// Checks.
	`LSE_ASSERT_IMPL(a_error_changes_nothing, result.valid && (result.status != ST_OK), !result.wrote && !result.taken)
	`LSE_ASSERT_NEXT(a_pc_holds_in_stall, s1_v && !en2, $stable(pc_q))
	`LSE_ASSERT_IMPL(a_pipe_empty_in_clear, clr_busy_q, !s1_v && !s2_v)

endmodule
